@@ src/tiny_language_lexer_assert.svh @@
// Assertion macros for the TINY lexer checker.
// Plain text macros only; no other dependencies.
`ifndef TINY_LANGUAGE_LEXER_ASSERT_SVH
`define TINY_LANGUAGE_LEXER_ASSERT_SVH

// Same-cycle implication under synchronous active-low reset.
`define TLL_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("lexer check failed");

// Next-cycle implication under synchronous active-low reset.
`define TLL_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("lexer check failed");

`endif

@@ src/tll_pkg.sv @@
// Shared types, token codes and scanner step function for the TINY lexer.
// No dependencies; used by every lexer module.
package tll_pkg;

    localparam int MAX_TOKEN_LEN_DEF = 40;
    localparam int CNT_W    = 6;
    localparam int LINE_W   = 16;
    localparam int KIND_W   = 5;
    localparam int PREFIX_N = 6;

    // Scanner states
    localparam logic [2:0] ST_START   = 3'd0;
    localparam logic [2:0] ST_ASSIGN  = 3'd1;
    localparam logic [2:0] ST_COMMENT = 3'd2;
    localparam logic [2:0] ST_NUM     = 3'd3;
    localparam logic [2:0] ST_ID      = 3'd4;

    // Token kinds
    localparam logic [4:0] KIND_ENDFILE = 5'd0;
    localparam logic [4:0] KIND_ERROR   = 5'd1;
    localparam logic [4:0] KIND_IF      = 5'd2;
    localparam logic [4:0] KIND_THEN    = 5'd3;
    localparam logic [4:0] KIND_ELSE    = 5'd4;
    localparam logic [4:0] KIND_END     = 5'd5;
    localparam logic [4:0] KIND_REPEAT  = 5'd6;
    localparam logic [4:0] KIND_UNTIL   = 5'd7;
    localparam logic [4:0] KIND_READ    = 5'd8;
    localparam logic [4:0] KIND_WRITE   = 5'd9;
    localparam logic [4:0] KIND_ID      = 5'd10;
    localparam logic [4:0] KIND_NUM     = 5'd11;
    localparam logic [4:0] KIND_ASSIGN  = 5'd12;
    localparam logic [4:0] KIND_EQ      = 5'd13;
    localparam logic [4:0] KIND_LT      = 5'd14;
    localparam logic [4:0] KIND_PLUS    = 5'd15;
    localparam logic [4:0] KIND_MINUS   = 5'd16;
    localparam logic [4:0] KIND_TIMES   = 5'd17;
    localparam logic [4:0] KIND_OVER    = 5'd18;
    localparam logic [4:0] KIND_LPAREN  = 5'd19;
    localparam logic [4:0] KIND_RPAREN  = 5'd20;
    localparam logic [4:0] KIND_SEMI    = 5'd21;

    typedef logic [PREFIX_N-1:0][7:0] prefix_t;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [CNT_W-1:0]  len;
        logic [LINE_W-1:0] line;
        logic              last;
    } tok_t;

    typedef struct packed {
        logic [2:0]       state;
        logic [CNT_W-1:0] count;
        prefix_t          prefix;
    } scan_regs_t;

    typedef struct packed {
        scan_regs_t        regs;
        logic              emit;
        logic [KIND_W-1:0] kind;
        logic [CNT_W-1:0]  len;
        logic              rescan;
    } step_t;

    typedef struct packed {
        prefix_t           text;
        logic [2:0]        len;
        logic [KIND_W-1:0] kind;
    } kw_t;

    function automatic logic is_digit(input logic [7:0] c);
        return c inside {["0":"9"]};
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return c inside {["a":"z"], ["A":"Z"]};
    endfunction

    function automatic logic [LINE_W-1:0] sat_inc(input logic [LINE_W-1:0] v, input logic en);
        return (en && (v != {LINE_W{1'b1}})) ? v + 1'b1 : v;
    endfunction

    // Reserved word table, first character in byte 0
    function automatic kw_t kw_entry(input logic [2:0] i);
        kw_t k;
        k.text = '0;
        case (i)
            3'd0: begin
                k.text[0] = "i"; k.text[1] = "f";
                k.len = 3'd2; k.kind = KIND_IF;
            end
            3'd1: begin
                k.text[0] = "t"; k.text[1] = "h"; k.text[2] = "e"; k.text[3] = "n";
                k.len = 3'd4; k.kind = KIND_THEN;
            end
            3'd2: begin
                k.text[0] = "e"; k.text[1] = "l"; k.text[2] = "s"; k.text[3] = "e";
                k.len = 3'd4; k.kind = KIND_ELSE;
            end
            3'd3: begin
                k.text[0] = "e"; k.text[1] = "n"; k.text[2] = "d";
                k.len = 3'd3; k.kind = KIND_END;
            end
            3'd4: begin
                k.text[0] = "r"; k.text[1] = "e"; k.text[2] = "p";
                k.text[3] = "e"; k.text[4] = "a"; k.text[5] = "t";
                k.len = 3'd6; k.kind = KIND_REPEAT;
            end
            3'd5: begin
                k.text[0] = "u"; k.text[1] = "n"; k.text[2] = "t";
                k.text[3] = "i"; k.text[4] = "l";
                k.len = 3'd5; k.kind = KIND_UNTIL;
            end
            3'd6: begin
                k.text[0] = "r"; k.text[1] = "e"; k.text[2] = "a"; k.text[3] = "d";
                k.len = 3'd4; k.kind = KIND_READ;
            end
            default: begin
                k.text[0] = "w"; k.text[1] = "r"; k.text[2] = "i";
                k.text[3] = "t"; k.text[4] = "e";
                k.len = 3'd5; k.kind = KIND_WRITE;
            end
        endcase
        return k;
    endfunction

    // Identifier or reserved word, by exact length and stored prefix
    function automatic logic [KIND_W-1:0] word_kind(input prefix_t p,
                                                    input logic [CNT_W-1:0] cnt);
        logic [KIND_W-1:0] k;
        kw_t e;
        logic hit;
        k = KIND_ID;
        for (int i = 0; i < 8; i++) begin
            e = kw_entry(3'(i));
            hit = (cnt == CNT_W'(e.len));
            for (int j = 0; j < PREFIX_N; j++) begin
                if ((3'(j) < e.len) && (p[j] != e.text[j])) begin
                    hit = 1'b0;
                end
            end
            if (hit) begin
                k = e.kind;
            end
        end
        return k;
    endfunction

    function automatic logic [KIND_W-1:0] single_kind(input logic [7:0] c);
        logic [KIND_W-1:0] k;
        case (c)
            "=":     k = KIND_EQ;
            "<":     k = KIND_LT;
            "+":     k = KIND_PLUS;
            "-":     k = KIND_MINUS;
            "*":     k = KIND_TIMES;
            "/":     k = KIND_OVER;
            "(":     k = KIND_LPAREN;
            ")":     k = KIND_RPAREN;
            ";":     k = KIND_SEMI;
            default: k = KIND_ERROR;
        endcase
        return k;
    endfunction

    // Store a lexeme character, saturating the count at max_len
    function automatic scan_regs_t save_char(input scan_regs_t r, input logic [7:0] c,
                                             input logic [CNT_W-1:0] max_len);
        scan_regs_t o;
        o = r;
        if (r.count < max_len) begin
            if (r.count < CNT_W'(PREFIX_N)) begin
                o.prefix[r.count[2:0]] = c;
            end
            o.count = r.count + 1'b1;
        end
        return o;
    endfunction

    // One pass of the scanner automaton
    function automatic step_t scan_step(input scan_regs_t r, input logic [7:0] c,
                                        input logic eof, input logic [CNT_W-1:0] max_len);
        step_t s;
        s.regs   = r;
        s.emit   = 1'b0;
        s.kind   = KIND_ERROR;
        s.len    = '0;
        s.rescan = 1'b0;
        case (r.state)
            ST_START: begin
                if (eof) begin
                    s.emit = 1'b1; s.kind = KIND_ENDFILE;
                end else if (is_digit(c)) begin
                    s.regs = save_char(r, c, max_len); s.regs.state = ST_NUM;
                end else if (is_alpha(c)) begin
                    s.regs = save_char(r, c, max_len); s.regs.state = ST_ID;
                end else if (c == ":") begin
                    s.regs = save_char(r, c, max_len); s.regs.state = ST_ASSIGN;
                end else if (c inside {" ", "\t", "\n"}) begin
                    s.regs = r;
                end else if (c == "{") begin
                    s.regs.state = ST_COMMENT;
                end else begin
                    s.regs = save_char(r, c, max_len);
                    s.emit = 1'b1; s.kind = single_kind(c);
                end
            end
            ST_COMMENT: begin
                if (eof) begin
                    s.emit = 1'b1; s.kind = KIND_ENDFILE;
                end else if (c == "}") begin
                    s.regs.state = ST_START;
                end
            end
            ST_ASSIGN: begin
                s.emit = 1'b1;
                if (!eof && (c == "=")) begin
                    s.regs = save_char(r, c, max_len); s.kind = KIND_ASSIGN;
                end else begin
                    s.kind = KIND_ERROR; s.rescan = 1'b1;
                end
            end
            ST_NUM: begin
                if (!eof && is_digit(c)) begin
                    s.regs = save_char(r, c, max_len);
                end else begin
                    s.emit = 1'b1; s.kind = KIND_NUM; s.rescan = 1'b1;
                end
            end
            ST_ID: begin
                if (!eof && is_alpha(c)) begin
                    s.regs = save_char(r, c, max_len);
                end else begin
                    s.emit = 1'b1; s.kind = word_kind(r.prefix, r.count); s.rescan = 1'b1;
                end
            end
            default: begin
                s.regs.state = ST_START;
                s.regs.count = '0;
            end
        endcase
        // Emit closes the lexeme and returns to start
        if (s.emit) begin
            s.len        = s.regs.count;
            s.regs.count = '0;
            s.regs.state = ST_START;
        end
        return s;
    endfunction

endpackage

@@ src/tll_scan.sv @@
// Scanner core: state registers, line counter and up to two tokens per character.
// Depends on tll_pkg.
module tll_scan #(
    parameter int MAX_TOKEN_LEN = tll_pkg::MAX_TOKEN_LEN_DEF
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          in_fire,
    input  logic [7:0]    char_in,
    input  logic          end_mark,
    output logic [1:0]    push_n,
    output tll_pkg::tok_t tok_a,
    output tll_pkg::tok_t tok_b
);
    import tll_pkg::*;

    localparam logic [CNT_W-1:0] MAX_LEN = CNT_W'(MAX_TOKEN_LEN);

    logic [2:0]        state_reg, state_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    prefix_t           prefix_reg, prefix_next;
    logic [LINE_W-1:0] line_reg, line_next;
    logic              started_reg, pend_reg;

    scan_regs_t        cur;
    step_t             s1, s2;
    logic [LINE_W-1:0] line1, line2;
    logic              e2;
    tok_t              t1, t2;

    // Run the first pass, then a re-scan from start when the token was terminated
    always_comb begin
        cur.state  = state_reg;
        cur.count  = count_reg;
        cur.prefix = prefix_reg;
        line1 = sat_inc(line_reg, started_reg && (end_mark || pend_reg));
        s1    = scan_step(cur, char_in, end_mark, MAX_LEN);
        line2 = sat_inc(line1, s1.rescan && end_mark);
        s2    = scan_step(s1.regs, char_in, end_mark, MAX_LEN);
        e2    = s1.rescan && s2.emit;

        state_next  = s1.rescan ? s2.regs.state  : s1.regs.state;
        count_next  = s1.rescan ? s2.regs.count  : s1.regs.count;
        prefix_next = s1.rescan ? s2.regs.prefix : s1.regs.prefix;
        line_next   = s1.rescan ? line2 : line1;

        t1 = '{kind: s1.kind, len: s1.len, line: line1, last: 1'b0};
        t2 = '{kind: s2.kind, len: s2.len, line: line2, last: 1'b1};
    end

    // Order the tokens and mark the final one
    always_comb begin
        tok_a = t1;
        tok_b = t2;
        if (s1.emit && e2) begin
            push_n = 2'd2;
        end else if (s1.emit) begin
            push_n     = 2'd1;
            tok_a.last = 1'b1;
        end else if (e2) begin
            push_n = 2'd1;
            tok_a  = t2;
        end else begin
            push_n = 2'd0;
        end
    end

    // Advance control state on each accepted transaction
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_START;
            count_reg   <= '0;
            line_reg    <= LINE_W'(1);
            started_reg <= 1'b0;
            pend_reg    <= 1'b0;
        end else if (in_fire) begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            line_reg    <= line_next;
            started_reg <= 1'b1;
            pend_reg    <= !end_mark && (char_in == "\n");
        end
    end

    // Hold the stored word prefix; only entries below the count are read
    always_ff @(posedge aclk) begin
        if (in_fire) begin
            prefix_reg <= prefix_next;
        end
    end

endmodule

@@ src/tll_out_buf.sv @@
// Two-entry result register that parts the scanner from the output stream.
// Depends on tll_pkg.
module tll_out_buf (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        push,
    input  logic [1:0]                  push_n,
    input  tll_pkg::tok_t               tok_a,
    input  tll_pkg::tok_t               tok_b,
    output logic                        can_push,
    output logic                        out_valid,
    input  logic                        out_ready,
    output tll_pkg::tok_t               out_tok
);
    import tll_pkg::*;

    tok_t q0_reg, q0_next, q1_reg, q1_next;
    logic v0_reg, v0_next, v1_reg, v1_next;
    logic pop;

    assign pop       = v0_reg && out_ready;
    // Room for two tokens once the head leaves
    assign can_push  = !v0_reg || (!v1_reg && out_ready);
    assign out_valid = v0_reg;
    assign out_tok   = q0_reg;

    // Drop the popped head, then append new tokens behind what stays
    always_comb begin
        if (pop) begin
            q0_next = q1_reg; v0_next = v1_reg;
            q1_next = q1_reg; v1_next = 1'b0;
        end else begin
            q0_next = q0_reg; v0_next = v0_reg;
            q1_next = q1_reg; v1_next = v1_reg;
        end
        if (push && (push_n != 2'd0)) begin
            if (!v0_next) begin
                q0_next = tok_a; v0_next = 1'b1;
                if (push_n == 2'd2) begin
                    q1_next = tok_b; v1_next = 1'b1;
                end
            end else begin
                q1_next = tok_a; v1_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
        end else begin
            v0_reg <= v0_next;
            v1_reg <= v1_next;
        end
    end

    always_ff @(posedge aclk) begin
        q0_reg <= q0_next;
        q1_reg <= q1_next;
    end

endmodule

@@ src/tiny_language_lexer.sv @@
// Top level of the TINY lexer: stream ports, scanner core and result register.
// Depends on tll_pkg, tll_scan and tll_out_buf.
//
//  channel | dir | tdata                           | tuser    | tlast
//  s_axis  | in  | char_in[7:0]                    | end_mark | -
//  m_axis  | out | kind[4:0] len[10:5] line[26:11] | -        | last_of_run
//
// A character is taken every cycle while s_axis_tready is high; its tokens sit in the result register the next cycle.
// A character that finishes two tokens fills both entries of the result register and
// holds s_axis_tready low until the first of them leaves.
// A stall on m_axis while a token waits holds s_axis_tready low until that token leaves.
// Reset (aresetn low, synchronous) returns to start state, line one, empty register.
module tiny_language_lexer #(
    parameter int MAX_TOKEN_LEN = tll_pkg::MAX_TOKEN_LEN_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] char_in
    input  logic        s_axis_tuser,   // [0] end_mark
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [4:0] token_kind, [10:5] token_length,
                                        // [26:11] line_number, [31:27] zero
    output logic        m_axis_tlast    // last_of_run
);
    import tll_pkg::*;

    logic       in_fire;
    logic       can_push;
    logic [1:0] push_n;
    tok_t       tok_a, tok_b, out_tok;

    assign s_axis_tready = can_push;
    assign in_fire       = s_axis_tvalid && can_push;

    tll_scan #(
        .MAX_TOKEN_LEN(MAX_TOKEN_LEN)
    ) u_scan (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_fire  (in_fire),
        .char_in  (s_axis_tdata),
        .end_mark (s_axis_tuser),
        .push_n   (push_n),
        .tok_a    (tok_a),
        .tok_b    (tok_b)
    );

    tll_out_buf u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (in_fire),
        .push_n    (push_n),
        .tok_a     (tok_a),
        .tok_b     (tok_b),
        .can_push  (can_push),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_tok   (out_tok)
    );

    // Pack the result transaction
    assign m_axis_tdata = {5'd0, out_tok.line, out_tok.len, out_tok.kind};
    assign m_axis_tlast = out_tok.last;

endmodule

@@ src/tll_checker.sv @@
// Port-level checks on the TINY lexer result stream, bound to the top level.
// Depends on tll_pkg and tiny_language_lexer_assert.svh.
`include "tiny_language_lexer_assert.svh"

module tll_checker #(
    parameter int MAX_TOKEN_LEN = tll_pkg::MAX_TOKEN_LEN_DEF
) (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [31:0] m_axis_tdata,
    input logic        m_axis_tlast
);
    import tll_pkg::*;

    localparam logic [CNT_W-1:0] MAX_LEN = CNT_W'(MAX_TOKEN_LEN);

    // Stalled result transaction holds
    `TLL_ASSERT_NEXT(a_hold, aclk, aresetn, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))

    // Kind is a defined token code
    `TLL_ASSERT_NOW(a_kind, aclk, aresetn, m_axis_tvalid, m_axis_tdata[4:0] <= KIND_SEMI)

    // Length saturates at the maximum
    `TLL_ASSERT_NOW(a_len, aclk, aresetn, m_axis_tvalid, m_axis_tdata[10:5] <= MAX_LEN)

    // End of file carries no characters and closes the run
    `TLL_ASSERT_NOW(a_eof, aclk, aresetn, m_axis_tvalid && (m_axis_tdata[4:0] == KIND_ENDFILE), (m_axis_tdata[10:5] == 6'd0) && m_axis_tlast)

endmodule

bind tiny_language_lexer tll_checker #(
    .MAX_TOKEN_LEN(MAX_TOKEN_LEN)
) u_tll_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);

@@ dv/testbench.sv @@
// Self-checking testbench for tiny_language_lexer: drives a byte stream, predicts the tokens.
// Needs tll_pkg and the lexer RTL; the predictor and scoreboard live in this file.
module testbench;
    import tll_pkg::*;

    localparam int STALL_LIMIT  = 3000;
    localparam int TARGET_ITEMS = 1700;
    localparam int HOLD_CYCLES  = 300;

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;
    logic        s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [31:0] m_axis_tdata;
    logic        m_axis_tlast;

    int src_idle_pct  = 35;
    int sink_idle_pct = 35;
    int sink_hold     = 0;
    int effective_items = 0;

    // Token predictor and in-order scoreboard
    class token_scoreboard;
        string       reserved_words[8];
        logic [2:0]  scan_st;
        logic [7:0]  word_head[6];
        logic [5:0]  lex_len;
        logic [15:0] cur_line;
        bit          line_opened;
        bit          newline_seen;
        tok_t        step_toks[$];
        tok_t        expected_tokens[$];
        int          mismatches;

        function new();
            reserved_words = '{"if", "then", "else", "end", "repeat", "until", "read", "write"};
            scan_st      = ST_START;
            lex_len      = '0;
            cur_line     = 16'd1;
            line_opened  = 1'b0;
            newline_seen = 1'b0;
            mismatches   = 0;
            foreach (word_head[i]) word_head[i] = 8'h00;
        endfunction

        function int pending();
            return expected_tokens.size();
        endfunction

        // Open a new line when a byte follows a newline; an end mark bumps too, but not on the first byte
        function void advance_line(logic [7:0] c, bit eof);
            if (!line_opened) begin
                line_opened = 1'b1;
            end else if ((eof || newline_seen) && cur_line != 16'hFFFF) begin
                cur_line = cur_line + 16'd1;
            end
            newline_seen = !eof && (c == "\n");
        endfunction

        // Append a lexeme byte; count saturates, only the head is kept
        function void keep_char(logic [7:0] c);
            if (lex_len < MAX_TOKEN_LEN_DEF) begin
                if (lex_len < 6) word_head[lex_len] = c;
                lex_len = lex_len + 6'd1;
            end
        endfunction

        function logic [4:0] classify_word();
            logic [4:0] k;
            bit hit;
            k = KIND_ID;
            for (int i = 0; i < 8; i++) begin
                if (reserved_words[i].len() == lex_len) begin
                    hit = 1'b1;
                    for (int j = 0; j < reserved_words[i].len(); j++) begin
                        if (reserved_words[i][j] != word_head[j]) hit = 1'b0;
                    end
                    if (hit) k = KIND_IF + 5'(i);
                end
            end
            return k;
        endfunction

        function logic [4:0] punct_kind(logic [7:0] c);
            case (c)
                "=":     return KIND_EQ;
                "<":     return KIND_LT;
                "+":     return KIND_PLUS;
                "-":     return KIND_MINUS;
                "*":     return KIND_TIMES;
                "/":     return KIND_OVER;
                "(":     return KIND_LPAREN;
                ")":     return KIND_RPAREN;
                ";":     return KIND_SEMI;
                default: return KIND_ERROR;
            endcase
        endfunction

        function void close_token(logic [4:0] kind);
            tok_t t;
            t.kind = kind;
            t.len  = lex_len;
            t.line = cur_line;
            t.last = 1'b0;
            step_toks.push_back(t);
            lex_len = '0;
            scan_st = ST_START;
        endfunction

        // One automaton pass; returns 1 when the symbol must be scanned again
        function bit scan_pass(logic [7:0] c, bit eof);
            case (scan_st)
                ST_START: begin
                    if (eof) begin
                        close_token(KIND_ENDFILE);
                    end else if (c >= "0" && c <= "9") begin
                        keep_char(c);
                        scan_st = ST_NUM;
                    end else if ((c >= "a" && c <= "z") || (c >= "A" && c <= "Z")) begin
                        keep_char(c);
                        scan_st = ST_ID;
                    end else if (c == ":") begin
                        keep_char(c);
                        scan_st = ST_ASSIGN;
                    end else if (c == "{") begin
                        scan_st = ST_COMMENT;
                    end else if (!(c == " " || c == "\t" || c == "\n")) begin
                        keep_char(c);
                        close_token(punct_kind(c));
                    end
                    return 1'b0;
                end
                ST_COMMENT: begin
                    if (eof) close_token(KIND_ENDFILE);
                    else if (c == "}") scan_st = ST_START;
                    return 1'b0;
                end
                ST_ASSIGN: begin
                    if (!eof && c == "=") begin
                        keep_char(c);
                        close_token(KIND_ASSIGN);
                        return 1'b0;
                    end
                    close_token(KIND_ERROR);
                    return 1'b1;
                end
                ST_NUM: begin
                    if (!eof && c >= "0" && c <= "9") begin
                        keep_char(c);
                        return 1'b0;
                    end
                    close_token(KIND_NUM);
                    return 1'b1;
                end
                ST_ID: begin
                    if (!eof && ((c >= "a" && c <= "z") || (c >= "A" && c <= "Z"))) begin
                        keep_char(c);
                        return 1'b0;
                    end
                    close_token(classify_word());
                    return 1'b1;
                end
                default: begin
                    scan_st = ST_START;
                    lex_len = '0;
                    return 1'b0;
                end
            endcase
        endfunction

        // Predict the tokens of one accepted transaction
        function void note_char(logic [7:0] c, bit eof);
            tok_t t;
            step_toks.delete();
            advance_line(c, eof);
            if (scan_pass(c, eof)) begin
                if (eof) advance_line(c, eof);
                void'(scan_pass(c, eof));
            end
            if (step_toks.size() > 0) begin
                t = step_toks.pop_back();
                t.last = 1'b1;
                step_toks.push_back(t);
            end
            foreach (step_toks[i]) expected_tokens.push_back(step_toks[i]);
        endfunction

        function void check_token(logic [4:0] kind, logic [5:0] len, logic [15:0] line,
                                  logic last);
            tok_t want;
            if (expected_tokens.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("token with none expected: kind %0d len %0d line %0d last %0b",
                             kind, len, line, last);
                return;
            end
            want = expected_tokens.pop_front();
            if (want.kind !== kind || want.len !== len || want.line !== line
                || want.last !== last) begin
                mismatches++;
                if (mismatches <= 10)
                    $display({"token mismatch: expected kind %0d len %0d line %0d last %0b, ",
                              "got kind %0d len %0d line %0d last %0b"},
                             want.kind, want.len, want.line, want.last, kind, len, line, last);
            end
        endfunction
    endclass

    token_scoreboard sb;

    tiny_language_lexer u_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    // 20-unit clock
    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // Offer one byte or end mark with random gaps; hold until the transaction completes
    task automatic send_char(input logic [7:0] c, input logic eof);
        @(negedge aclk);
        while ($urandom_range(99) < src_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= c;
        s_axis_tuser  <= eof;
        @(posedge aclk);
        while (!s_axis_tready) @(posedge aclk);
        sb.note_char(c, eof);
        effective_items++;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++) send_char(s[i], 1'b0);
    endtask

    // Stop offering and wait until every predicted token has been seen
    task automatic drain_results();
        @(negedge aclk);
        s_axis_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
    endtask

    function automatic logic [7:0] random_letter();
        if ($urandom_range(1) == 1) return 8'("a" + $urandom_range(25));
        return 8'("A" + $urandom_range(25));
    endfunction

    // One source fragment, mostly well formed, then an optional separator
    task automatic send_random_token();
        string w;
        string ops;
        int pick, n, spot, mode;
        logic [7:0] ch;
        ops  = "=<+-*/();";
        pick = $urandom_range(99);
        if (pick < 20) begin
            send_text(sb.reserved_words[$urandom_range(7)]);
        end else if (pick < 30) begin
            // near miss of a reserved word: case flip, truncation or extra letter
            w    = sb.reserved_words[$urandom_range(7)];
            spot = $urandom_range(w.len() - 1);
            mode = $urandom_range(2);
            n    = (mode == 1 && spot > 0) ? spot : w.len();
            for (int i = 0; i < n; i++) begin
                ch = w[i];
                if (mode == 0 && i == spot) ch = ch ^ 8'h20;
                send_char(ch, 1'b0);
            end
            if (mode == 2) send_char(random_letter(), 1'b0);
        end else if (pick < 45) begin
            repeat ($urandom_range(1, 8)) send_char(random_letter(), 1'b0);
        end else if (pick < 60) begin
            repeat ($urandom_range(1, 6)) send_char(8'("0" + $urandom_range(9)), 1'b0);
        end else if (pick < 62) begin
            // lexeme around and beyond the saturation length
            case ($urandom_range(4))
                0:       n = 39;
                1:       n = 40;
                2:       n = 41;
                3:       n = 47;
                default: n = 63;
            endcase
            mode = $urandom_range(1);
            repeat (n) begin
                if (mode == 1) send_char(random_letter(), 1'b0);
                else send_char(8'("0" + $urandom_range(9)), 1'b0);
            end
        end else if (pick < 68) begin
            send_text(":=");
        end else if (pick < 71) begin
            send_char(":", 1'b0);
        end else if (pick < 83) begin
            send_char(ops[$urandom_range(8)], 1'b0);
        end else if (pick < 89) begin
            send_char("{", 1'b0);
            repeat ($urandom_range(8)) begin
                ch = 8'($urandom_range(255));
                if (ch == "}") ch = "\n";
                send_char(ch, 1'b0);
            end
            if ($urandom_range(9) != 0) send_char("}", 1'b0);
        end else if (pick < 93) begin
            send_char(8'($urandom_range(255)), 1'b0);
        end else if (pick < 95) begin
            send_char(8'($urandom_range(255)), 1'b1);
        end else begin
            repeat ($urandom_range(1, 3)) send_char("\n", 1'b0);
        end
        if ($urandom_range(99) < 55) begin
            case ($urandom_range(2))
                0:       send_char(" ", 1'b0);
                1:       send_char("\t", 1'b0);
                default: send_char("\n", 1'b0);
            endcase
        end
    endtask

    // Result side: random back-pressure plus requested long hold-offs
    initial begin : sink
        m_axis_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (sink_hold > 0) begin
                sink_hold--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= ($urandom_range(99) >= sink_idle_pct);
            end
        end
    end

    // Check each completed result transaction
    always @(posedge aclk) begin
        if (aresetn && m_axis_tvalid && m_axis_tready)
            sb.check_token(m_axis_tdata[4:0], m_axis_tdata[10:5], m_axis_tdata[26:11],
                           m_axis_tlast);
    end

    // End the run if neither channel moves for too long
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge aclk);
            if (!aresetn || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                quiet = 0;
            else
                quiet++;
        end
        $display("*** FAILED ***");
        $finish;
    end

    initial begin : stimulus
        int token_idx;
        aresetn       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = 8'h00;
        s_axis_tuser  = 1'b0;
        sb = new();
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed: keyword, assign, two tokens from one byte, lone colon, end mark
        // after an identifier, odd bytes, unterminated comment, bytes after the end
        send_text("if ");
        send_text(":=");
        send_text("7<");
        send_text(":a");
        send_char(8'hFF, 1'b1);
        send_char(8'hFF, 1'b0);
        send_char(8'h00, 1'b0);
        send_char(8'h0D, 1'b0);
        send_text("\n{");
        send_char(8'h00, 1'b1);
        send_text("+-*/()=;");

        // Random source text with phases of back-pressure and drain pauses
        token_idx = 0;
        while (effective_items < TARGET_ITEMS) begin
            if (token_idx == 40 || token_idx == 200) sink_hold = HOLD_CYCLES;
            if (token_idx == 90 || token_idx == 250) drain_results();
            if (token_idx == 110) begin
                src_idle_pct  = 0;
                sink_idle_pct = 0;
            end
            if (token_idx == 170) begin
                src_idle_pct  = 35;
                sink_idle_pct = 35;
            end
            send_random_token();
            token_idx++;
        end
        send_char(8'h00, 1'b1);

        drain_results();
        repeat (20) @(posedge aclk);
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

@@ files.f @@
+incdir+src
src/tll_pkg.sv
src/tll_scan.sv
src/tll_out_buf.sv
src/tiny_language_lexer.sv
src/tll_checker.sv
dv/testbench.sv
